@@ rtl/pca_pkg.sv @@
// Shared types, constants and saturating helpers for the PID controller.
// No dependencies; every other file uses these by scoped name.
package pca_pkg;

   localparam int DataWidth = 32;              // values, gains, limits
   localparam int AccWidth  = DataWidth + 16;  // term accumulator and integral
   localparam int ProdWidth = AccWidth + DataWidth; // raw magnitude product
   localparam int CntWidth  = 7;
   localparam int MulSteps  = DataWidth;       // one multiplier bit a cycle
   localparam int DivSteps  = ProdWidth;       // one quotient bit a cycle
   localparam logic [31:0] StepTimeMin = 32'd429; // 1.0e-7 s in Q0.32

   typedef enum logic [2:0] {
      REG_GAIN_P     = 3'd0,
      REG_GAIN_I     = 3'd1,
      REG_GAIN_D     = 3'd2,
      REG_LIMIT_LOW  = 3'd3,
      REG_LIMIT_HIGH = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_P      = 3'd0,
      OP_INCR   = 3'd1,
      OP_ITRIAL = 3'd2,
      OP_IOLD   = 3'd3,
      OP_DPROD  = 3'd4,
      OP_DIV    = 3'd5
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   sum1;
      logic   sum2;
      logic   finish;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic bad;
      logic gd_zero;
      logic out_free;
   } stat_type;

   // magnitude plus sign to a saturated signed accumulator value
   function automatic logic signed [AccWidth-1:0] sat_mag(
      input logic [ProdWidth-1:0] m, input logic neg);
      logic [AccWidth-1:0] v;
      logic signed [AccWidth-1:0] r;
      v = {1'b0, m[AccWidth-2:0]};
      if (|m[ProdWidth-1:AccWidth-1]) begin
         r = neg ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
      end else begin
         r = neg ? $signed(~v + 1'b1) : $signed(v);
      end
      return r;
   endfunction

   function automatic logic signed [AccWidth-1:0] sat_add(
      input logic signed [AccWidth-1:0] a, input logic signed [AccWidth-1:0] b);
      logic [AccWidth:0] s;
      logic signed [AccWidth-1:0] r;
      s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
      if (s[AccWidth] != s[AccWidth-1]) begin
         r = s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
      end else begin
         r = $signed(s[AccWidth-1:0]);
      end
      return r;
   endfunction

   function automatic logic [DataWidth-1:0] abs_data(input logic [DataWidth-1:0] x);
      return x[DataWidth-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [AccWidth-1:0] abs_acc(input logic [AccWidth-1:0] x);
      return x[AccWidth-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [DataWidth:0] abs_diff(input logic [DataWidth:0] x);
      return x[DataWidth] ? (~x + 1'b1) : x;
   endfunction

endpackage

@@ rtl/pca_ctrl.sv @@
// Sequencer for the PID controller: issues multiply, divide and sum commands.
// Depends on pca_pkg for the command and status structs.
module pca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pca_pkg::stat_type stat,
   output pca_pkg::cmd_type  cmd,
   output logic              idle
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_P, ST_INCR, ST_ITRIAL, ST_IOLD, ST_DPROD, ST_DIV,
      ST_SUM1, ST_SUM2, ST_FIN, ST_LAST
   } state_type;

   state_type        state_ff, state_in;
   pca_pkg::cmd_type cmd_ff, cmd_in;

   always_comb begin
      state_in = state_ff;
      cmd_in   = '0;
      cmd_in.op = pca_pkg::OP_P;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_P;
               cmd_in.start = 1'b1;
               cmd_in.op    = pca_pkg::OP_P;
            end
         end
         ST_P: begin
            if (stat.done) begin
               cmd_in.start = 1'b1;
               if (stat.bad) begin
                  state_in  = ST_IOLD;
                  cmd_in.op = pca_pkg::OP_IOLD;
               end else begin
                  state_in  = ST_INCR;
                  cmd_in.op = pca_pkg::OP_INCR;
               end
            end
         end
         ST_INCR: begin
            if (stat.done) begin
               state_in     = ST_ITRIAL;
               cmd_in.start = 1'b1;
               cmd_in.op    = pca_pkg::OP_ITRIAL;
            end
         end
         ST_ITRIAL: begin
            if (stat.done) begin
               state_in     = ST_IOLD;
               cmd_in.start = 1'b1;
               cmd_in.op    = pca_pkg::OP_IOLD;
            end
         end
         ST_IOLD: begin
            if (stat.done) begin
               if (stat.bad || stat.gd_zero) begin
                  state_in    = ST_SUM1;
                  cmd_in.sum1 = 1'b1;
               end else begin
                  state_in     = ST_DPROD;
                  cmd_in.start = 1'b1;
                  cmd_in.op    = pca_pkg::OP_DPROD;
               end
            end
         end
         ST_DPROD: begin
            if (stat.done) begin
               state_in     = ST_DIV;
               cmd_in.start = 1'b1;
               cmd_in.op    = pca_pkg::OP_DIV;
            end
         end
         ST_DIV: begin
            if (stat.done) begin
               state_in    = ST_SUM1;
               cmd_in.sum1 = 1'b1;
            end
         end
         ST_SUM1: begin
            state_in    = ST_SUM2;
            cmd_in.sum2 = 1'b1;
         end
         ST_SUM2: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait for the output register to be free
            if (stat.out_free) begin
               state_in      = ST_LAST;
               cmd_in.finish = 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd  = cmd_ff;
   assign idle = (state_ff == ST_IDLE);

endmodule

@@ rtl/pca_datapath.sv @@
// Datapath of the PID controller: registers, shift-add multiplier, restoring
// divider, saturating sums and the output register. Depends on pca_pkg.
module pca_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic signed [pca_pkg::DataWidth-1:0]   req_target,
   input  logic signed [pca_pkg::DataWidth-1:0]   req_measured,
   input  logic        [31:0]                     req_step_time,
   input  logic                                   csr_wr_en,
   input  logic        [2:0]                      csr_index,
   input  logic        [pca_pkg::DataWidth-1:0]   csr_wr_data,
   input  pca_pkg::cmd_type                       cmd,
   input  logic                                   rsp_stall,
   output pca_pkg::stat_type                      stat,
   output logic                                   rsp_valid,
   output logic signed [pca_pkg::DataWidth-1:0]   rsp_drive,
   output logic                                   rsp_integral_held,
   output logic                                   rsp_step_time_bad
);

   localparam int DW = pca_pkg::DataWidth;
   localparam int AW = pca_pkg::AccWidth;
   localparam int PW = pca_pkg::ProdWidth;
   localparam int CW = pca_pkg::CntWidth;

   // configuration
   logic signed [DW-1:0] gain_p_ff, gain_i_ff, gain_d_ff, limit_low_ff, limit_high_ff;

   // controller state
   logic signed [AW-1:0] integral_ff;
   logic signed [DW-1:0] last_err_ff;

   // per-word operands
   logic signed [DW-1:0] err_ff;
   logic        [DW:0]   diff_ff;
   logic        [31:0]   st_ff;

   // iterative unit
   logic                 busy_ff, done_ff;
   logic [CW-1:0]        cnt_ff;
   logic [PW-1:0]        acc_ff;
   logic [AW-1:0]        ma_ff;
   logic [DW-1:0]        mb_ff;
   logic [31:0]          rem_ff;
   logic                 neg_ff;
   pca_pkg::op_type      op_ff;

   // partial results
   logic signed [AW-1:0] p_ff, tint_ff, it_ff, io_ff, d_ff;
   logic signed [AW-1:0] pi_ff, po_ff, trial_ff, other_ff;

   // output register
   logic                 rsp_valid_ff, held_ff, bad_out_ff;
   logic signed [DW-1:0] drive_ff;

   // error on load, saturated to the data width
   logic [DW:0]          raw_err;
   logic signed [DW-1:0] err_in;
   logic [DW:0]          diff_in;

   always_comb begin
      raw_err = {req_target[DW-1], req_target} - {req_measured[DW-1], req_measured};
      if (raw_err[DW] != raw_err[DW-1]) begin
         err_in = raw_err[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         err_in = $signed(raw_err[DW-1:0]);
      end
      diff_in = {err_in[DW-1], err_in} - {last_err_ff[DW-1], last_err_ff};
   end

   logic bad;
   logic gd_zero;
   assign bad     = (st_ff <= pca_pkg::StepTimeMin);
   assign gd_zero = (gain_d_ff == '0);

   // divider step
   logic [32:0] rem_sh;
   logic        q_bit;
   logic [32:0] rem_sub;
   always_comb begin
      rem_sh  = {rem_ff, acc_ff[PW-1]};
      q_bit   = (rem_sh >= {1'b0, st_ff});
      rem_sub = rem_sh - {1'b0, st_ff};
   end

   // result assembly
   logic signed [AW-1:0] d_eff, lo_ext, hi_ext;
   logic                 out_of_range;
   logic signed [DW-1:0] clamped;
   always_comb begin
      d_eff        = (bad || gd_zero) ? '0 : d_ff;
      lo_ext       = AW'(limit_low_ff);
      hi_ext       = AW'(limit_high_ff);
      out_of_range = (trial_ff > hi_ext) || (trial_ff < lo_ext);
      if (other_ff > hi_ext) begin
         clamped = limit_high_ff;
      end else if (other_ff < lo_ext) begin
         clamped = limit_low_ff;
      end else begin
         clamped = other_ff[DW-1:0];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_low_ff  <= -32'sd65536;
         limit_high_ff <= 32'sd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            pca_pkg::REG_GAIN_P:     gain_p_ff     <= $signed(csr_wr_data);
            pca_pkg::REG_GAIN_I:     gain_i_ff     <= $signed(csr_wr_data);
            pca_pkg::REG_GAIN_D:     gain_d_ff     <= $signed(csr_wr_data);
            pca_pkg::REG_LIMIT_LOW:  limit_low_ff  <= $signed(csr_wr_data);
            pca_pkg::REG_LIMIT_HIGH: limit_high_ff <= $signed(csr_wr_data);
            default: ;
         endcase
      end
   end

   // state and word capture
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         last_err_ff <= '0;
      end else begin
         if (load) begin
            last_err_ff <= err_in;
         end
         if (cmd.finish && !bad && !out_of_range) begin
            integral_ff <= tint_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
         st_ff   <= req_step_time;
      end
   end

   // iterative multiply and divide
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= pca_pkg::OP_P;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            op_ff   <= cmd.op;
            cnt_ff  <= (cmd.op == pca_pkg::OP_DIV) ? CW'(pca_pkg::DivSteps - 1)
                                                    : CW'(pca_pkg::MulSteps - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         case (cmd.op)
            pca_pkg::OP_P: begin
               ma_ff  <= AW'(pca_pkg::abs_data(err_ff));
               mb_ff  <= pca_pkg::abs_data(gain_p_ff);
               neg_ff <= err_ff[DW-1] ^ gain_p_ff[DW-1];
               acc_ff <= '0;
            end
            pca_pkg::OP_INCR: begin
               ma_ff  <= AW'(pca_pkg::abs_data(err_ff));
               mb_ff  <= st_ff;
               neg_ff <= err_ff[DW-1];
               acc_ff <= '0;
            end
            pca_pkg::OP_ITRIAL: begin
               ma_ff  <= pca_pkg::abs_acc(tint_ff);
               mb_ff  <= pca_pkg::abs_data(gain_i_ff);
               neg_ff <= tint_ff[AW-1] ^ gain_i_ff[DW-1];
               acc_ff <= '0;
            end
            pca_pkg::OP_IOLD: begin
               ma_ff  <= pca_pkg::abs_acc(integral_ff);
               mb_ff  <= pca_pkg::abs_data(gain_i_ff);
               neg_ff <= integral_ff[AW-1] ^ gain_i_ff[DW-1];
               acc_ff <= '0;
            end
            pca_pkg::OP_DPROD: begin
               ma_ff  <= AW'(pca_pkg::abs_diff(diff_ff));
               mb_ff  <= pca_pkg::abs_data(gain_d_ff);
               neg_ff <= diff_ff[DW] ^ gain_d_ff[DW-1];
               acc_ff <= '0;
            end
            pca_pkg::OP_DIV: begin
               // numerator is the product scaled by 2^16; sign carries over
               acc_ff <= {acc_ff[PW-17:0], 16'b0};
               rem_ff <= '0;
            end
            default: ;
         endcase
      end else if (busy_ff) begin
         if (op_ff == pca_pkg::OP_DIV) begin
            rem_ff <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
            acc_ff <= {acc_ff[PW-2:0], q_bit};
         end else begin
            acc_ff <= {acc_ff[PW-2:0], 1'b0} + (mb_ff[DW-1] ? PW'(ma_ff) : '0);
            mb_ff  <= {mb_ff[DW-2:0], 1'b0};
         end
      end
   end

   // store finished unit results and form sums
   always_ff @(posedge clock) begin
      if (done_ff) begin
         case (op_ff)
            pca_pkg::OP_P:      p_ff  <= pca_pkg::sat_mag(PW'(acc_ff[PW-1:16]), neg_ff);
            pca_pkg::OP_INCR:   tint_ff <= pca_pkg::sat_add(integral_ff,
                                   pca_pkg::sat_mag(PW'(acc_ff[PW-1:16]), neg_ff));
            pca_pkg::OP_ITRIAL: it_ff <= pca_pkg::sat_mag(PW'(acc_ff[PW-1:32]), neg_ff);
            pca_pkg::OP_IOLD:   io_ff <= pca_pkg::sat_mag(PW'(acc_ff[PW-1:32]), neg_ff);
            pca_pkg::OP_DIV:    d_ff  <= pca_pkg::sat_mag(acc_ff, neg_ff);
            default: ;
         endcase
      end
      if (cmd.sum1) begin
         pi_ff <= pca_pkg::sat_add(p_ff, it_ff);
         po_ff <= pca_pkg::sat_add(p_ff, io_ff);
      end
      if (cmd.sum2) begin
         trial_ff <= pca_pkg::sat_add(pi_ff, d_eff);
         other_ff <= pca_pkg::sat_add(po_ff, d_eff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         bad_out_ff <= bad;
         if (bad) begin
            held_ff  <= 1'b0;
            drive_ff <= clamped;
         end else if (out_of_range) begin
            held_ff  <= 1'b1;
            drive_ff <= clamped;
         end else begin
            held_ff  <= 1'b0;
            drive_ff <= trial_ff[DW-1:0];
         end
      end
   end

   assign stat.done     = done_ff;
   assign stat.bad      = bad;
   assign stat.gd_zero  = gd_zero;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_integral_held = held_ff;
   assign rsp_step_time_bad = bad_out_ff;

endmodule

@@ rtl/pid_conditional_antiwindup.sv @@
// Top level of the PID controller with conditional-integration anti-windup.
// Depends on pca_pkg, pca_ctrl and pca_datapath.
//
// One word in gives one word out. Values, gains and limits are signed
// Q16.16, the step time is unsigned Q0.32 seconds and the integral is kept
// as signed Q16.32 in 48 bits; every product and quotient truncates toward
// zero and every sum saturates. The block takes one word at a time: req_stall
// is low only while the sequencer is idle. A word with a bad step time
// (at or below 429, i.e. 1.0e-7 s) skips the increment, trial-integral and
// derivative products and the divide; zero derivative gain skips the last two.
// The sequencer is idle again as the result shows on rsp_valid. Work is done
// by the shared shift-add multiplier (operand load, 32 add-shift steps and a
// done cycle a product; up to five products), the restoring divider (one
// quotient bit a cycle) and the steps that sum, clamp and register the result.
// A finished word waits in the output register, so the next word is taken
// while rsp_stall holds the previous one; a word still held there when the
// next one is ready stretches the last step until rsp_stall drops. Write the
// csr_ registers only while the block is idle; writes to indexes beyond
// limit_high are dropped.
module pid_conditional_antiwindup (
   input  logic                                 clock,
   input  logic                                 reset,
   // input word
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pca_pkg::DataWidth-1:0] req_target,
   input  logic signed [pca_pkg::DataWidth-1:0] req_measured,
   input  logic        [31:0]                   req_step_time,
   // result word
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pca_pkg::DataWidth-1:0] rsp_drive,
   output logic                                 rsp_integral_held,
   output logic                                 rsp_step_time_bad,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic        [2:0]                    csr_index,
   input  logic        [pca_pkg::DataWidth-1:0] csr_wr_data
);

   pca_pkg::cmd_type  cmd;
   pca_pkg::stat_type stat;
   logic              idle;
   logic              accept;

   // take a word only when the sequencer has nothing in flight
   assign req_stall = !idle;
   assign accept    = req_valid && idle;

   pca_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .cmd    (cmd),
      .idle   (idle)
   );

   pca_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .req_target        (req_target),
      .req_measured      (req_measured),
      .req_step_time     (req_step_time),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .rsp_stall         (rsp_stall),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_drive         (rsp_drive),
      .rsp_integral_held (rsp_integral_held),
      .rsp_step_time_bad (rsp_step_time_bad)
   );

endmodule

@@ verif/pid_conditional_antiwindup_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the PID controller with conditional anti-windup.
// Depends on pca_pkg and the pid_conditional_antiwindup RTL.

// Checks every result word against a fixed-point model of the controller.
class pid_scoreboard;
   typedef struct {
      logic signed [31:0] drive;
      logic               held;
      logic               bad;
   } result_type;

   localparam longint AccMax = (longint'(1) <<< 47) - 1;
   localparam longint AccMin = -(longint'(1) <<< 47);

   longint gain_p, gain_i, gain_d, limit_low, limit_high;
   longint integral_sum, last_error;
   result_type expected_words[$];
   int errors;

   function new();
      gain_p = 0; gain_i = 0; gain_d = 0;
      limit_low = -65536; limit_high = 65536;
      integral_sum = 0; last_error = 0; errors = 0;
   endfunction

   function longint sat48(longint x);
      if (x > AccMax) return AccMax;
      if (x < AccMin) return AccMin;
      return x;
   endfunction

   function longint add48(longint a, longint b);
      return sat48(a + b);
   endfunction

   function longint from_mag(logic [127:0] m, bit neg);
      if (neg) return (m > 128'(AccMax) + 1) ? AccMin : -longint'(m[63:0]);
      return (m > 128'(AccMax)) ? AccMax : longint'(m[63:0]);
   endfunction

   function logic [127:0] mag_prod(longint a, longint b);
      logic [63:0] ma, mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      return {64'd0, ma} * {64'd0, mb};
   endfunction

   // product shifted right, truncated toward zero, saturated to 48 bits
   function longint scaled_product(longint a, longint b, int sh);
      return from_mag(mag_prod(a, b) >> sh, (a < 0) != (b < 0));
   endfunction

   // (a*b << 16) / den, truncated toward zero, saturated to 48 bits
   function longint scaled_quotient(longint a, longint b, longint den);
      return from_mag((mag_prod(a, b) << 16) / 128'(den), (a < 0) != (b < 0));
   endfunction

   function longint clamp_out(longint v);
      if (v > limit_high) return limit_high;
      if (v < limit_low) return limit_low;
      return v;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      longint v;
      v = longint'($signed(value));
      case (idx)
         pca_pkg::REG_GAIN_P:     gain_p = v;
         pca_pkg::REG_GAIN_I:     gain_i = v;
         pca_pkg::REG_GAIN_D:     gain_d = v;
         pca_pkg::REG_LIMIT_LOW:  limit_low = v;
         pca_pkg::REG_LIMIT_HIGH: limit_high = v;
         default: ;
      endcase
   endfunction

   // work out the result of one accepted input word and queue it
   function void note_input(logic signed [31:0] target, logic signed [31:0] measured,
                            logic [31:0] step_time);
      longint err, prev, p, incr, trial_int, d, trial, out;
      longint st;
      result_type w;
      st = longint'(step_time);
      err = longint'(target) - longint'(measured);
      if (err > 64'sd2147483647) err = 64'sd2147483647;
      if (err < -64'sd2147483648) err = -64'sd2147483648;
      prev = last_error;
      last_error = err;
      p = scaled_product(gain_p, err, 16);
      w.held = 1'b0;
      w.bad = 1'b0;
      if (step_time <= pca_pkg::StepTimeMin) begin
         w.bad = 1'b1;
         out = clamp_out(add48(p, scaled_product(gain_i, integral_sum, 32)));
      end else begin
         incr = scaled_product(err, st, 16);
         trial_int = add48(integral_sum, incr);
         d = 0;
         if (gain_d != 0) d = scaled_quotient(gain_d, err - prev, st);
         trial = add48(add48(p, scaled_product(gain_i, trial_int, 32)), d);
         if (trial > limit_high || trial < limit_low) begin
            w.held = 1'b1;
            out = clamp_out(add48(add48(p, scaled_product(gain_i, integral_sum, 32)), d));
         end else begin
            integral_sum = trial_int;
            out = trial;
         end
      end
      w.drive = out[31:0];
      expected_words.push_back(w);
   endfunction

   task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task check_result(logic signed [31:0] drive, logic held, logic bad);
      result_type w;
      if (expected_words.size() == 0) begin
         report($sformatf("unexpected word drive=%0d", drive));
         return;
      end
      w = expected_words.pop_front();
      if (drive !== w.drive)
         report($sformatf("drive %0d, expected %0d", drive, w.drive));
      if (held !== w.held)
         report($sformatf("integral_held %b, expected %b", held, w.held));
      if (bad !== w.bad)
         report($sformatf("step_time_bad %b, expected %b", bad, w.bad));
   endtask

   function int pending();
      return expected_words.size();
   endfunction
endclass

module pid_conditional_antiwindup_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_target = '0;
   logic signed [31:0] req_measured = '0;
   logic        [31:0] req_step_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic               rsp_integral_held;
   logic               rsp_step_time_bad;
   logic               csr_wr_en = 1'b0;
   logic        [2:0]  csr_index = '0;
   logic        [31:0] csr_wr_data = '0;

   pid_scoreboard controller_model = new();
   int burst_left = 0;
   int stall_mode = 0;
   int stall_count = 0;

   pid_conditional_antiwindup dut (.*);

   always #5 clock = ~clock;

   // Watch both channels; sampled values are the ones before this edge's updates.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         controller_model.note_input(req_target, req_measured, req_step_time);
      if (!reset && rsp_valid && !rsp_stall)
         controller_model.check_result(rsp_drive, rsp_integral_held, rsp_step_time_bad);
   end

   // Receiver stall: switch between patterns on a stall_count period, from none to heavy.
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_count % 64) < 40;
      endcase
   end

   // Write one register at the next edge; the model takes it on the same edge.
   // Drop the enable after the write, so back-to-back writes stay apart.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      controller_model.write_reg(idx, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drain: wait until every expected word has come, then let the block settle.
   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      burst_left = 0;
      while (controller_model.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_all(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                          logic [31:0] lo, logic [31:0] hi);
      drain();
      write_reg(pca_pkg::REG_GAIN_P, gp);
      write_reg(pca_pkg::REG_GAIN_I, gi);
      write_reg(pca_pkg::REG_GAIN_D, gd);
      write_reg(pca_pkg::REG_LIMIT_LOW, lo);
      write_reg(pca_pkg::REG_LIMIT_HIGH, hi);
   endtask

   // Offer one word; hold valid across a burst, drop it for a random gap after.
   task automatic send_word(logic [31:0] target, logic [31:0] measured,
                            logic [31:0] step_time);
      if (burst_left == 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_target <= target;
      req_measured <= measured;
      req_step_time <= step_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   function automatic logic [31:0] pick_step_time();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 429);
         1: return $urandom;
         2: return 32'd430;
         default: return $urandom_range(430, 32'h0100_0000);
      endcase
   endfunction

   // Mostly plausible loop traffic, sometimes full-range noise.
   task automatic random_words(int count);
      logic signed [31:0] setpoint, plant;
      setpoint = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      plant = 0;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 15) == 0)
               setpoint = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            plant = plant + ((setpoint - plant) >>> 2)
                    + $signed($urandom_range(0, 2047)) - 1024;
            send_word(setpoint, plant, pick_step_time());
         end else begin
            send_word($urandom, $urandom, pick_step_time());
         end
      end
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      // reset settings: all gains zero, so drive stays at zero
      send_word(32'sh0001_0000, 32'sh0, 32'd65536);
      send_word(32'sh8000_0000, 32'sh7fff_ffff, 32'd0);

      // directed: extremes of every field, bad and boundary step times
      set_all(32'h0001_0000, 32'h0002_0000, 32'h0000_0100, 32'hfffe_0000, 32'h0002_0000);
      send_word(32'sh7fff_ffff, 32'sh8000_0000, 32'd429);
      send_word(32'sh8000_0000, 32'sh7fff_ffff, 32'd430);
      send_word(32'sh0000_8000, 32'sh0, 32'hffff_ffff);
      send_word(32'sh0, 32'sh0, 32'd0);
      send_word(32'sh0001_0000, 32'sh0000_4000, 32'd430);
      send_word(32'shffff_ffff, 32'sh0000_0001, 32'd65536);
      send_word(32'sh0, 32'sh0000_0100, 32'd1);
      send_word(32'sh0000_1000, 32'sh0, 32'h0100_0000);
      // zero derivative gain, full-range gains
      set_all(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
      send_word(32'sh7fff_ffff, 32'sh0, 32'hffff_ffff);
      send_word(32'sh8000_0000, 32'sh0, 32'hffff_ffff);
      send_word(32'sh0000_0001, 32'sh0, 32'd430);
      // crossed limits: every trial counts as out of range
      set_all(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000);
      send_word(32'sh0000_8000, 32'sh0, 32'd430);
      send_word(32'sh0, 32'sh0000_8000, 32'h8000_0000);
      send_word(32'sh0, 32'sh0, 32'd100);
      // out-of-range indexes must be dropped
      drain();
      for (int idx = int'(pca_pkg::REG_LIMIT_HIGH) + 1; idx < 8; idx++)
         write_reg(3'(idx), $urandom);
      send_word(32'sh0001_0000, 32'sh0, 32'd65536);

      // random phases over several settings, the extremes among them
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: set_all(pick_gain(), pick_gain(), pick_gain(), 32'hffff_0000, 32'h0001_0000);
            1: set_all(pick_gain(), pick_gain(), 32'h0, 32'h8000_0000, 32'h7fff_ffff);
            2: set_all($urandom, $urandom, $urandom, $urandom, $urandom);
            default: set_all(pick_gain(), pick_gain(), pick_gain(),
                             -$signed($urandom_range(0, 32'h0010_0000)),
                             $urandom_range(0, 32'h0010_0000));
         endcase
         random_words(128);
      end

      drain();
      if (controller_model.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
